// ----- design/rcss_pkg.sv -----
package rcss_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned LEN_W     = 6;
	localparam int unsigned FILL_W    = 6;
	localparam int unsigned SUM_W     = 16;
	localparam int unsigned GRP_W     = 11;
	localparam int unsigned COUNT_W   = 5;
	localparam int unsigned OUT_POS_W = 32;
	localparam int unsigned OFFSET_W  = 32;
	localparam int unsigned WORD_W    = 64;
	localparam int unsigned PAT_BYTES = 32;
	localparam int unsigned PAT_W     = PAT_BYTES * BYTE_W;
	localparam int unsigned PIDX_W    = $clog2(PAT_BYTES);
	localparam int unsigned MODE_W    = 2;
	localparam int unsigned CFG_IDX_W = 3;

	localparam int unsigned COLL_SPAN_MUL = 10;
	localparam int unsigned COLL_BASE     = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_3 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_CHECKSUM_MODE  = 3'd6;

	localparam logic [MODE_W-1:0] MODE_FAST_SWITCH = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SLOW        = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FAST        = 2'd2;

	typedef struct packed {
		logic [LEN_W-1:0]    length;
		logic [PAT_W-1:0]    pattern;
		logic [OFFSET_W-1:0] start_offset;
		logic [MODE_W-1:0]   mode;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] text_byte;
		logic              last;
		logic              searching;
		logic [FILL_W-1:0] filled;
	} front_item_t;

	typedef struct packed {
		logic                 found;
		logic [OUT_POS_W-1:0] match_position;
		logic                 used_slow;
	} result_t;

	function automatic logic [BYTE_W-1:0] pat_byte(input logic [PAT_W-1:0] pat,
		input logic [PIDX_W-1:0] idx);
		return pat[{idx, 3'b000} +: BYTE_W];
	endfunction

endpackage

// ----- design/rcss_fifo.sv -----
module rcss_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/rcss_front.sv -----
module rcss_front import rcss_pkg::*; #(
	parameter int unsigned POSITION_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     take,
	input  logic [BYTE_W-1:0]        text_byte,
	input  logic                     last_byte,
	input  logic [OFFSET_W-1:0]      start_offset,
	output front_item_t              item,
	output logic [POSITION_BITS-1:0] next_pos,
	output logic [POSITION_BITS-1:0] pos_from_offset
);

	localparam int unsigned CMP_W = (POSITION_BITS > OFFSET_W) ? POSITION_BITS : OFFSET_W;

	logic [POSITION_BITS-1:0] index_q;
	logic [FILL_W-1:0]        fill_q;
	logic [FILL_W-1:0]        fill_next;
	logic                     searching;

	assign searching       = CMP_W'(index_q) >= CMP_W'(start_offset);
	assign next_pos        = index_q + 1'b1;
	assign pos_from_offset = next_pos - POSITION_BITS'(start_offset);

	always_comb begin
		fill_next = fill_q;
		if (searching && (fill_q != '1)) begin
			fill_next = fill_q + 1'b1;
		end
	end

	assign item = '{
		text_byte: text_byte,
		last:      last_byte,
		searching: searching,
		filled:    fill_next
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q <= '0;
			fill_q  <= '0;
		end else if (take) begin
			if (last_byte) begin
				index_q <= '0;
				fill_q  <= '0;
			end else begin
				index_q <= next_pos;
				fill_q  <= fill_next;
			end
		end
	end

endmodule

// ----- design/rcss_back.sv -----
module rcss_back import rcss_pkg::*; #(
	parameter int unsigned PATTERN_MAX   = 32,
	parameter int unsigned POSITION_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  logic                     in_valid,
	input  front_item_t              in_item,
	input  logic [POSITION_BITS-1:0] in_next_pos,
	input  logic [POSITION_BITS-1:0] in_pos_from_offset,
	output logic                     in_pop,
	input  logic                     out_full,
	output logic                     out_push,
	output result_t                  out_res
);

	localparam int unsigned NGRP   = (PATTERN_MAX + 7) / 8;
	localparam int unsigned WIDX_W = $clog2(PATTERN_MAX);

	logic [BYTE_W-1:0] window_q [PATTERN_MAX];
	logic [BYTE_W-1:0] wb_new   [PATTERN_MAX];
	logic [GRP_W-1:0]  wsum     [NGRP];
	logic [GRP_W-1:0]  psum     [NGRP];
	logic [GRP_W-1:0]  pp_q     [NGRP];
	logic [LEN_W-1:0]  ts;
	logic [SUM_W-1:0]  edge_d;
	logic              same_d;
	logic [SUM_W-1:0]  two_tm1;

	logic                     valid_s1;
	logic                     last_s1;
	logic                     searching_s1;
	logic [FILL_W-1:0]        filled_s1;
	logic [GRP_W-1:0]         wsum_s1 [NGRP];
	logic [SUM_W-1:0]         edge_s1;
	logic                     same_s1;
	logic [POSITION_BITS-1:0] p_s1;
	logic [POSITION_BITS-1:0] pmo_s1;
	logic [POSITION_BITS-1:0] pos_s1;

	logic                     done_q;
	logic                     slow_q;
	logic [POSITION_BITS-1:0] origin_q;
	logic [COUNT_W-1:0]       count_q;

	logic [SUM_W-1:0]         fs, ss, ft, st, wtmp, ptmp;
	logic                     slow_now, hit, cand, found_now, coll, emit, slow_end;
	logic                     done_d, slow_d;
	logic [POSITION_BITS-1:0] origin_d;
	logic [POSITION_BITS-1:0] org_diff;
	logic [COUNT_W-1:0]       count_d, count_inc;
	logic [LEN_W:0]           thresh;
	logic [8:0]               span;
	logic                     adv;

	assign ts      = cfg.length;
	assign two_tm1 = SUM_W'({ts - 1'b1, 1'b0});

	always_comb begin
		wb_new[0] = in_item.text_byte;
		for (int j = 1; j < PATTERN_MAX; j++) begin
			wb_new[j] = window_q[j-1];
		end
		for (int g = 0; g < NGRP; g++) begin
			wsum[g] = '0;
			psum[g] = '0;
			for (int e = 0; e < 8; e++) begin
				if ((g * 8 + e < PATTERN_MAX) && (g * 8 + e + 1 < int'(ts))) begin
					wsum[g] = wsum[g] + GRP_W'(wb_new[g*8+e]);
				end
				if ((g * 8 + e >= 1) && (g * 8 + e < int'(ts))) begin
					psum[g] = psum[g] + GRP_W'(pat_byte(cfg.pattern, PIDX_W'(g * 8 + e)));
				end
			end
		end
		edge_d = SUM_W'(wb_new[WIDX_W'(ts - 1'b1)]) - SUM_W'(wb_new[0]);
		same_d = 1'b1;
		for (int j = 0; j < PATTERN_MAX; j++) begin
			if (j < int'(ts)) begin
				if (wb_new[j] != pat_byte(cfg.pattern, PIDX_W'(int'(ts) - 1 - j))) begin
					same_d = 1'b0;
				end
			end
		end
	end

	always_comb begin
		fs = '0;
		ft = '0;
		for (int g = 0; g < NGRP; g++) begin
			fs = fs + SUM_W'(wsum_s1[g]);
			ft = ft + SUM_W'(pp_q[g]);
		end
		wtmp = fs + edge_s1;
		ss   = fs + (wtmp << 1) + two_tm1;
		ptmp = ft + SUM_W'(pat_byte(cfg.pattern, '0))
			- SUM_W'(pat_byte(cfg.pattern, PIDX_W'(ts - 1'b1)));
		st   = ft + (ptmp << 1) + two_tm1;

		slow_now  = (cfg.mode == MODE_SLOW) || ((cfg.mode == MODE_FAST_SWITCH) && slow_q);
		hit       = slow_now ? (ss == st) : (fs == ft);
		cand      = valid_s1 && searching_s1 && !done_q && (filled_s1 >= ts) && hit;
		found_now = cand && same_s1;
		coll      = cand && !same_s1 && (filled_s1 > ts)
			&& (cfg.mode == MODE_FAST_SWITCH) && !slow_q;

		span      = 9'(ts) * 9'(COLL_SPAN_MUL);
		org_diff  = p_s1 - origin_q;
		count_inc = count_q + 1'b1;
		thresh    = (LEN_W + 1)'(COLL_BASE) + (LEN_W + 1)'(ts >> 1);
		origin_d  = origin_q;
		count_d   = count_q;
		slow_d    = slow_q;
		if (coll) begin
			if (origin_q == '0) begin
				origin_d = pmo_s1;
				count_d  = COUNT_W'(1);
			end else if (org_diff > POSITION_BITS'(span)) begin
				origin_d = p_s1;
				count_d  = COUNT_W'(1);
			end else begin
				count_d = count_inc;
				if ((LEN_W + 1)'(count_inc) > thresh) begin
					slow_d = 1'b1;
				end
			end
		end
		done_d   = done_q || found_now;
		emit     = found_now || (valid_s1 && last_s1 && !done_d);
		slow_end = (cfg.mode == MODE_SLOW) || ((cfg.mode == MODE_FAST_SWITCH) && slow_d);

		out_res.found          = found_now;
		out_res.match_position = found_now ? OUT_POS_W'(pos_s1) : '0;
		out_res.used_slow      = found_now ? slow_now : slow_end;
	end

	assign adv      = !(emit && out_full);
	assign in_pop   = in_valid && adv;
	assign out_push = emit && !out_full;

	always_ff @(posedge clk) begin
		if (in_pop) begin
			last_s1      <= in_item.last;
			searching_s1 <= in_item.searching;
			filled_s1    <= in_item.filled;
			wsum_s1      <= wsum;
			edge_s1      <= edge_d;
			same_s1      <= same_d;
			p_s1         <= in_next_pos;
			pmo_s1       <= in_pos_from_offset;
			pos_s1       <= in_next_pos - POSITION_BITS'(ts);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pp_q     <= '{default: '0};
			window_q <= '{default: '0};
			done_q   <= 1'b0;
			slow_q   <= 1'b0;
			origin_q <= '0;
			count_q  <= '0;
		end else begin
			pp_q <= psum;
			if (adv) begin
				valid_s1 <= in_valid;
			end
			if (in_pop) begin
				if (in_item.last) begin
					window_q <= '{default: '0};
				end else if (in_item.searching) begin
					window_q <= wb_new;
				end
			end
			if (valid_s1 && adv) begin
				if (last_s1) begin
					done_q   <= 1'b0;
					slow_q   <= 1'b0;
					origin_q <= '0;
					count_q  <= '0;
				end else begin
					done_q   <= done_d;
					slow_q   <= slow_d;
					origin_q <= origin_d;
					count_q  <= count_d;
				end
			end
		end
	end

endmodule

// ----- design/rolling_checksum_substring_search.sv -----
// Channel   Handshake               Payload
// input     push / full             text_byte, last_byte
// result    empty / pop             found, match_position, used_slow_checksum
// config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One text byte per cycle sustained unless a full result queue stalls it; the
// window compare and checksum tree are registered before a result is queued.
// Reset is asynchronous and clears the window, indexes and collision state at
// once; the block takes items in the first cycle after reset.
// A two-entry queue sits between the front and the back end, and a two-entry
// queue holds results; full rises only when the back end waits on pop.
module rolling_checksum_substring_search import rcss_pkg::*; #(
	parameter int unsigned PATTERN_MAX   = 32,
	parameter int unsigned POSITION_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [BYTE_W-1:0]    text_byte,
	input  logic                 last_byte,
	output logic                 empty,
	input  logic                 pop,
	output logic                 found,
	output logic [OUT_POS_W-1:0] match_position,
	output logic                 used_slow_checksum,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data
);

	localparam int unsigned MID_W = $bits(front_item_t) + 2 * POSITION_BITS;

	logic [LEN_W-1:0]    len_q;
	logic [PAT_W-1:0]    pattern_q;
	logic [OFFSET_W-1:0] offset_q;
	logic [MODE_W-1:0]   mode_q;
	logic [LEN_W-1:0]    eff_len;
	cfg_t                cfg;

	front_item_t              f_item;
	logic [POSITION_BITS-1:0] f_next_pos;
	logic [POSITION_BITS-1:0] f_pos_from_offset;
	logic                     take;

	logic [MID_W-1:0]         mid_rdata;
	logic                     mid_empty;
	logic                     mid_pop;
	front_item_t              b_item;
	logic [POSITION_BITS-1:0] b_next_pos;
	logic [POSITION_BITS-1:0] b_pos_from_offset;

	logic    out_full;
	logic    out_push;
	result_t out_res;
	result_t res_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= LEN_W'(1);
			pattern_q <= '0;
			offset_q  <= '0;
			mode_q    <= MODE_FAST_SWITCH;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PATTERN_LENGTH: len_q <= cfg_data[LEN_W-1:0];
				CFG_PATTERN_WORD_0: pattern_q[0*WORD_W +: WORD_W] <= cfg_data;
				CFG_PATTERN_WORD_1: pattern_q[1*WORD_W +: WORD_W] <= cfg_data;
				CFG_PATTERN_WORD_2: pattern_q[2*WORD_W +: WORD_W] <= cfg_data;
				CFG_PATTERN_WORD_3: pattern_q[3*WORD_W +: WORD_W] <= cfg_data;
				CFG_START_OFFSET:   offset_q <= cfg_data[OFFSET_W-1:0];
				CFG_CHECKSUM_MODE:  mode_q <= cfg_data[MODE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		eff_len = len_q;
		if (len_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (len_q > LEN_W'(PATTERN_MAX)) begin
			eff_len = LEN_W'(PATTERN_MAX);
		end
	end

	assign cfg = '{
		length:       eff_len,
		pattern:      pattern_q,
		start_offset: offset_q,
		mode:         mode_q
	};

	assign take = push && !full;

	rcss_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (take),
		.text_byte      (text_byte),
		.last_byte      (last_byte),
		.start_offset   (offset_q),
		.item           (f_item),
		.next_pos       (f_next_pos),
		.pos_from_offset(f_pos_from_offset)
	);

	rcss_fifo #(
		.WIDTH(MID_W),
		.DEPTH(2)
	) u_mid_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (take),
		.wdata ({f_item, f_next_pos, f_pos_from_offset}),
		.rd    (mid_pop),
		.rdata (mid_rdata),
		.full  (full),
		.empty (mid_empty)
	);

	assign {b_item, b_next_pos, b_pos_from_offset} = mid_rdata;

	rcss_back #(
		.PATTERN_MAX  (PATTERN_MAX),
		.POSITION_BITS(POSITION_BITS)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg),
		.in_valid          (!mid_empty),
		.in_item           (b_item),
		.in_next_pos       (b_next_pos),
		.in_pos_from_offset(b_pos_from_offset),
		.in_pop            (mid_pop),
		.out_full          (out_full),
		.out_push          (out_push),
		.out_res           (out_res)
	);

	rcss_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(2)
	) u_out_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (out_push),
		.wdata (out_res),
		.rd    (pop),
		.rdata (res_head),
		.full  (out_full),
		.empty (empty)
	);

	assign found              = res_head.found;
	assign match_position     = res_head.match_position;
	assign used_slow_checksum = res_head.used_slow;

endmodule

// ----- verif/search_result_checker.sv -----
module search_result_checker import rcss_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 full,
	input  logic [BYTE_W-1:0]    text_byte,
	input  logic                 last_byte,
	input  logic                 empty,
	input  logic                 pop,
	input  logic                 found,
	input  logic [OUT_POS_W-1:0] match_position,
	input  logic                 used_slow_checksum,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	input  logic                 drained,
	output int unsigned          pending,
	output int unsigned          fail_count
);

	localparam int unsigned POS_W = 32;

	logic [LEN_W-1:0]    len_q;
	logic [PAT_W-1:0]    pat_q;
	logic [OFFSET_W-1:0] offset_q;
	logic [MODE_W-1:0]   mode_q;

	logic [BYTE_W-1:0]   window [PAT_BYTES];
	logic [POS_W-1:0]    text_pos;
	logic [POS_W-1:0]    coll_origin;
	logic [COUNT_W-1:0]  coll_count;
	logic                slow_on;
	logic                search_done;
	logic                flushed;

	result_t             match_q[$];
	result_t             want;

	function automatic logic [BYTE_W-1:0] pattern_at(input int unsigned i);
		return pat_q[BYTE_W*i +: BYTE_W];
	endfunction

	task automatic report(input string msg);
		$display("%0t: search result mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic clear_text();
		for (int j = 0; j < PAT_BYTES; j++) begin
			window[j] = '0;
		end
		text_pos = '0;
		coll_origin = '0;
		coll_count = '0;
		slow_on = 1'b0;
		search_done = 1'b0;
	endtask

	task automatic search_step(input logic [BYTE_W-1:0] b, input logic fin);
		int unsigned      ts;
		logic [POS_W-1:0] k;
		logic [POS_W-1:0] p;
		logic [POS_W:0]   filled;
		logic [SUM_W-1:0] fs, ss, ft, st;
		logic             slow_now, hit, same;
		result_t          r;
		ts = (len_q == 0) ? 1 : ((len_q > PAT_BYTES) ? PAT_BYTES : len_q);
		k = text_pos;
		slow_now = (mode_q == MODE_SLOW) || (mode_q == MODE_FAST_SWITCH && slow_on);
		if (!search_done && k >= offset_q) begin
			filled = {1'b0, k} - {1'b0, offset_q} + 1'b1;
			for (int j = PAT_BYTES - 1; j > 0; j--) begin
				window[j] = window[j - 1];
			end
			window[0] = b;
			fs = '0;
			ss = '0;
			ft = '0;
			st = '0;
			for (int j = 0; j + 1 < ts; j++) begin
				fs = fs + window[j];
				ss = ss + 2 * (window[j + 1] + 1) + window[j];
			end
			for (int j = 1; j < ts; j++) begin
				ft = ft + pattern_at(j);
				st = st + 2 * (pattern_at(j - 1) + 1) + pattern_at(j);
			end
			if (filled >= ts) begin
				hit = slow_now ? (ss == st) : (fs == ft);
				same = 1'b1;
				for (int j = 0; j < ts; j++) begin
					if (window[ts - 1 - j] != pattern_at(j))
						same = 1'b0;
				end
				if (hit && same) begin
					r.found = 1'b1;
					r.match_position = k + 1 - ts;
					r.used_slow = slow_now;
					match_q.push_back(r);
					search_done = 1'b1;
				end else if (hit && filled > ts && mode_q == MODE_FAST_SWITCH && !slow_on) begin
					p = k + 1;
					if (coll_origin == 0) begin
						coll_origin = p - offset_q;
						coll_count = 1;
					end else if (POS_W'(p - coll_origin) > ts * COLL_SPAN_MUL) begin
						coll_origin = p;
						coll_count = 1;
					end else begin
						coll_count = coll_count + 1'b1;
						if (coll_count > COLL_BASE + ts / 2)
							slow_on = 1'b1;
					end
				end
			end
		end
		if (fin) begin
			if (!search_done) begin
				r.found = 1'b0;
				r.match_position = '0;
				r.used_slow = (mode_q == MODE_SLOW) || (mode_q == MODE_FAST_SWITCH && slow_on);
				match_q.push_back(r);
			end
			clear_text();
		end else begin
			text_pos = k + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q = 1;
			pat_q = '0;
			offset_q = '0;
			mode_q = MODE_FAST_SWITCH;
			clear_text();
			match_q.delete();
			flushed = 1'b0;
			fail_count = 0;
			pending <= 0;
		end else begin
			if (pop && !empty) begin
				if (match_q.size() == 0) begin
					report($sformatf("unexpected result found=%b position %0d",
						found, match_position));
				end else begin
					want = match_q.pop_front();
					if (found !== want.found)
						report($sformatf("found %b, expected %b", found, want.found));
					if (match_position !== want.match_position)
						report($sformatf("match_position %0d, expected %0d",
							match_position, want.match_position));
					if (used_slow_checksum !== want.used_slow)
						report($sformatf("used_slow_checksum %b, expected %b",
							used_slow_checksum, want.used_slow));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PATTERN_LENGTH: len_q = cfg_data[LEN_W-1:0];
					CFG_PATTERN_WORD_0: pat_q[0*WORD_W +: WORD_W] = cfg_data;
					CFG_PATTERN_WORD_1: pat_q[1*WORD_W +: WORD_W] = cfg_data;
					CFG_PATTERN_WORD_2: pat_q[2*WORD_W +: WORD_W] = cfg_data;
					CFG_PATTERN_WORD_3: pat_q[3*WORD_W +: WORD_W] = cfg_data;
					CFG_START_OFFSET:   offset_q = cfg_data[OFFSET_W-1:0];
					CFG_CHECKSUM_MODE:  mode_q = cfg_data[MODE_W-1:0];
					default: ;
				endcase
			end
			if (push && !full)
				search_step(text_byte, last_byte);
			if (drained && !flushed) begin
				flushed = 1'b1;
				while (match_q.size() != 0) begin
					want = match_q.pop_front();
					report($sformatf("missing result found=%b position %0d",
						want.found, want.match_position));
				end
			end
			pending <= match_q.size();
		end
	end

endmodule

// ----- verif/rolling_checksum_substring_search_tb.sv -----
module rolling_checksum_substring_search_tb;
	import rcss_pkg::*;

	localparam int unsigned ITEM_TARGET = 1250;
	localparam int unsigned CALM_FROM   = 1080;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned SETTLE_CYC  = 6;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 full;
	logic [BYTE_W-1:0]    text_byte = '0;
	logic                 last_byte = 1'b0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic                 found;
	logic [OUT_POS_W-1:0] match_position;
	logic                 used_slow_checksum;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_PATTERN_LENGTH;
	logic [WORD_W-1:0]    cfg_data = '0;
	logic                 drained = 1'b0;
	int unsigned          pending;
	int unsigned          fail_count;

	int unsigned          quiet_cycles = 0;
	int unsigned          sent = 0;
	int unsigned          gap_pct = 0;
	int unsigned          stall_pct = 0;
	logic                 calm = 1'b0;
	int unsigned          cur_ts = 1;
	int unsigned          cur_base = 0;
	logic [PAT_W-1:0]     cur_pat = '0;
	logic [BYTE_W-1:0]    alpha [4];
	int unsigned          alpha_n = 0;

	rolling_checksum_substring_search u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.push               (push),
		.full               (full),
		.text_byte          (text_byte),
		.last_byte          (last_byte),
		.empty              (empty),
		.pop                (pop),
		.found              (found),
		.match_position     (match_position),
		.used_slow_checksum (used_slow_checksum),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data)
	);

	search_result_checker u_chk (
		.clk                (clk),
		.arst_n             (arst_n),
		.push               (push),
		.full               (full),
		.text_byte          (text_byte),
		.last_byte          (last_byte),
		.empty              (empty),
		.pop                (pop),
		.found              (found),
		.match_position     (match_position),
		.used_slow_checksum (used_slow_checksum),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.drained            (drained),
		.pending            (pending),
		.fail_count         (fail_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 99) < stall_pct) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			pop <= 1'b1;
		end
	end

	function automatic logic [BYTE_W-1:0] pick_byte();
		if (alpha_n == 0)
			return BYTE_W'($urandom);
		return alpha[$urandom_range(0, alpha_n - 1)];
	endfunction

	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		push <= 1'b1;
		text_byte <= b;
		last_byte <= fin;
		@(posedge clk);
		while (full) @(posedge clk);
		sent++;
	endtask

	// hold input until every pending result is out and the pipe has emptied
	task automatic settle();
		push <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic configure(input logic [LEN_W-1:0] len, input logic [PAT_W-1:0] pat,
		input logic [OFFSET_W-1:0] off, input logic [MODE_W-1:0] mode);
		write_reg(CFG_PATTERN_LENGTH, WORD_W'(len));
		write_reg(CFG_PATTERN_WORD_0, pat[0*WORD_W +: WORD_W]);
		write_reg(CFG_PATTERN_WORD_1, pat[1*WORD_W +: WORD_W]);
		write_reg(CFG_PATTERN_WORD_2, pat[2*WORD_W +: WORD_W]);
		write_reg(CFG_PATTERN_WORD_3, pat[3*WORD_W +: WORD_W]);
		write_reg(CFG_START_OFFSET, WORD_W'(off));
		write_reg(CFG_CHECKSUM_MODE, WORD_W'(mode));
		cfg_valid <= 1'b0;
		cur_ts = (len == 0) ? 1 : ((len > PAT_BYTES) ? PAT_BYTES : len);
		cur_pat = pat;
		cur_base = (off <= 12) ? off : 0;
	endtask

	task automatic run_text(input int unsigned n, input logic plant, input int unsigned at);
		logic [BYTE_W-1:0] b;
		for (int unsigned i = 0; i < n; i++) begin
			if (plant && i >= at && i < at + cur_ts)
				b = cur_pat[BYTE_W*(i - at) +: BYTE_W];
			else
				b = pick_byte();
			send_byte(b, i == n - 1);
		end
	endtask

	initial begin
		logic [PAT_W-1:0]    pat;
		logic [LEN_W-1:0]    len;
		logic [OFFSET_W-1:0] off;
		logic [MODE_W-1:0]   mode;
		int unsigned         n, at, texts, pick;
		logic                plant;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		settle();

		// zero length acts as one, unused mode acts as fast; match on the last byte
		configure('0, PAT_W'(8'hFF), '0, MODE_UNUSED);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		settle();

		// oversize length with slow checksum; text ends inside the first window
		configure('1, '1, '0, MODE_SLOW);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		settle();

		// text ends before the offset, then a match followed by ignored bytes
		configure(LEN_W'(2), PAT_W'(16'h6261), OFFSET_W'(3), MODE_FAST);
		send_byte(8'h61, 1'b0);
		send_byte(8'h62, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h62, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		settle();

		for (int i = 0; i < PAT_BYTES; i++)
			pat[BYTE_W*i +: BYTE_W] = BYTE_W'($urandom);
		configure(LEN_W'(PAT_BYTES), pat, '1, MODE_FAST_SWITCH);
		send_byte(8'hFF, 1'b1);

		while (sent < ITEM_TARGET) begin
			settle();
			pick = $urandom_range(0, 19);
			if (pick == 0)
				len = '0;
			else if (pick == 1)
				len = LEN_W'($urandom_range(PAT_BYTES + 1, 63));
			else if (pick < 5)
				len = LEN_W'($urandom_range(9, PAT_BYTES));
			else
				len = LEN_W'($urandom_range(1, 8));
			pick = $urandom_range(0, 2);
			alpha_n = (pick == 0) ? 0 : ((pick == 1) ? 2 : 4);
			for (int i = 0; i < 4; i++)
				alpha[i] = BYTE_W'($urandom);
			for (int i = 0; i < PAT_BYTES; i++)
				pat[BYTE_W*i +: BYTE_W] = pick_byte();
			pick = $urandom_range(0, 9);
			if (pick < 6)
				off = '0;
			else if (pick < 9)
				off = OFFSET_W'($urandom_range(1, 12));
			else
				off = OFFSET_W'($urandom);
			pick = $urandom_range(0, 5);
			mode = (pick < 3) ? MODE_FAST_SWITCH :
				((pick == 3) ? MODE_SLOW : ((pick == 4) ? MODE_FAST : MODE_UNUSED));
			configure(len, pat, off, mode);
			pick = $urandom_range(0, 2);
			gap_pct = (pick == 0) ? 0 : ((pick == 1) ? 10 : 35);
			pick = $urandom_range(0, 2);
			stall_pct = (pick == 0) ? 0 : ((pick == 1) ? 10 : 35);
			texts = $urandom_range(4, 10);
			repeat (texts) begin
				if (sent >= ITEM_TARGET)
					break;
				if (sent >= CALM_FROM)
					calm = 1'b1;
				if ($urandom_range(0, 4) == 0)
					n = $urandom_range(1, cur_base + cur_ts);
				else
					n = cur_base + cur_ts + $urandom_range(0, 40);
				plant = ($urandom_range(0, 2) != 0) && (n >= cur_base + cur_ts);
				at = plant ? $urandom_range(cur_base, n - cur_ts) : 0;
				run_text(n, plant, at);
			end
		end

		push <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
		drained <= 1'b1;
		repeat (2) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
